[hw/rtl/sblc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_pkg
// Shared types and constants of the size-budgeted LRU cache.
// ----------------------------------------------------------------------------
package sblc_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  localparam int unsigned USED_W = 24;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned OWN_W  = 4;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CTR_W  = 32;
  localparam int unsigned CMD_W  = 3;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 160;

  localparam logic [USED_W-1:0] USED_MAX     = {USED_W{1'b1}};
  localparam logic [USED_W-1:0] BUDGET_RESET = 24'd262144;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP      = 3'd0,
    CMD_INSERT      = 3'd1,
    CMD_REMOVE      = 3'd2,
    CMD_CLEAR       = 3'd3,
    CMD_RESET_STATS = 3'd4
  } cmd_e;

endpackage

[hw/rtl/size_budget_lru_cache_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_budget_lru_cache_core
// Sixteen-slot LRU cache of owner/key entries held under a byte budget.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: the command in tuser, the owner,
// key and entry size in tdata. Each request yields one or more results on
// the m_axis channel; tlast marks the closing result of a request, and
// tuser flags a lookup hit or a reported (evicted or cleared) entry.
// The user writes the byte budget through cfg_we_i / cfg_wdata_i while idle;
// the block itself does not enforce this. One request is worked on at a
// time; s_axis_tready is high only when idle. Lookup, insert and remove
// first scan the table for the owner/key pair with one shared comparator,
// one slot a cycle. An insert then drops a duplicate and evicts the oldest
// entries, each one reported, while over budget or full; a clear reports
// every entry as it drops it. Rank updates touch all slots in parallel.
// Results leave through an output register; when the receiver stalls, the
// sequencer waits in place with its pending result and loses nothing.
// Reset empties the table, zeroes the byte total and the counters, and
// sets the budget to 262144 bytes. Slot payloads are not cleared.
// ----------------------------------------------------------------------------
module size_budget_lru_cache_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sblc_pkg::USED_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tuser: command
  input  logic [sblc_pkg::CMD_W-1:0]         s_axis_tuser,
  // tdata: owner_id[3:0], glyph_key[35:4], entry_bytes[51:36], zero fill
  input  logic [sblc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic                               m_axis_tlast,
  // tuser: lookup_hit[0], dropped_valid[1]
  output logic [1:0]                         m_axis_tuser,
  // tdata: dropped_owner[3:0], dropped_key[35:4], bytes_in_use[59:36],
  // hits_total[91:60], misses_total[123:92], evictions_total[155:124], fill
  output logic [sblc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned SW = sblc_pkg::SLOT_W;
  localparam int unsigned N  = sblc_pkg::SLOTS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DUP   = 4'd2;
  localparam logic [3:0] S_EVCHK = 4'd3;
  localparam logic [3:0] S_EVRD  = 4'd4;
  localparam logic [3:0] S_INS   = 4'd5;
  localparam logic [3:0] S_LKUP  = 4'd6;
  localparam logic [3:0] S_RMV   = 4'd7;
  localparam logic [3:0] S_CLCHK = 4'd8;
  localparam logic [3:0] S_CLRD  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  logic [sblc_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [sblc_pkg::OWN_W-1:0]  owner_q, owner_d;
  logic [sblc_pkg::KEY_W-1:0]  key_q, key_d;
  logic [sblc_pkg::SIZE_W-1:0] nbytes_q, nbytes_d;
  logic                        found_q, found_d;
  logic [SW-1:0]               idx_q, idx_d;
  logic [SW-1:0]               scan_q, scan_d;

  logic [sblc_pkg::USED_W-1:0] budget_q;
  logic [sblc_pkg::USED_W-1:0] used_q, used_d;
  logic [sblc_pkg::CTR_W-1:0]  hits_q, hits_d, misses_q, misses_d, evicts_q, evicts_d;

  logic [N-1:0]                valid_q, valid_d;
  logic [sblc_pkg::OWN_W-1:0]  slot_owner_q [N];
  logic [sblc_pkg::KEY_W-1:0]  slot_key_q   [N];
  logic [sblc_pkg::SIZE_W-1:0] slot_bytes_q [N];
  logic [SW-1:0]               slot_rank_q  [N];
  logic [SW-1:0]               rank_d       [N];

  // Output register
  logic                        ov_q, ov_d, olast_q, olast_d, ohit_q, ohit_d, odv_q, odv_d;
  logic [sblc_pkg::OWN_W-1:0]  oowner_q, oowner_d;
  logic [sblc_pkg::KEY_W-1:0]  okey_q, okey_d;
  logic [sblc_pkg::USED_W-1:0] oused_q, oused_d;
  logic [sblc_pkg::CTR_W-1:0]  ohits_q, ohits_d, omiss_q, omiss_d, oev_q, oev_d;

  logic                        do_promote, do_drop, do_insert;
  logic [SW-1:0]               rd_idx;
  logic [SW-1:0]               rrank;
  logic [sblc_pkg::SIZE_W-1:0] rbytes;
  logic [sblc_pkg::USED_W-1:0] used_sub;
  logic [sblc_pkg::USED_W:0]   used_sum;
  logic [sblc_pkg::USED_W:0]   ins_sum;
  logic [sblc_pkg::CNT_W-1:0]  cnt;
  logic                        free_found;
  logic [SW-1:0]               free_idx;
  logic                        vic_found;
  logic [SW-1:0]               vic_idx;
  logic [SW-1:0]               vic_rank;
  logic                        need_evict;
  logic                        out_free;
  logic                        in_acc;
  logic                        slot_match;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign rd_idx   = (state_q == S_SCAN) ? scan_q : idx_q;
  assign rrank    = slot_rank_q[rd_idx];
  assign rbytes   = slot_bytes_q[rd_idx];
  assign cnt      = sblc_pkg::CNT_W'($countones(valid_q));

  // The shared comparator: one slot against the requested owner and key.
  assign slot_match = valid_q[rd_idx] && (slot_owner_q[rd_idx] == owner_q)
                      && (slot_key_q[rd_idx] == key_q);

  assign used_sub = (used_q >= sblc_pkg::USED_W'(rbytes))
                    ? used_q - sblc_pkg::USED_W'(rbytes) : '0;
  assign used_sum = {1'b0, used_q} + (sblc_pkg::USED_W + 1)'(nbytes_q);
  assign ins_sum  = {1'b0, used_q} + (sblc_pkg::USED_W + 1)'(nbytes_q);
  assign need_evict = (used_sum > {1'b0, budget_q}) || !free_found;

  // Oldest entry has rank cnt-1, newest rank 0; ranks form a permutation.
  assign vic_rank = (state_q == S_CLCHK) ? '0 : SW'(cnt - 1'b1);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    vic_found  = 1'b0;
    vic_idx    = '0;
    for (int j = N - 1; j >= 0; j--) begin
      if (!valid_q[j]) begin
        free_found = 1'b1;
        free_idx   = SW'(j);
      end
      if (valid_q[j] && slot_rank_q[j] == vic_rank) begin
        vic_found = 1'b1;
        vic_idx   = SW'(j);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    owner_d  = owner_q;
    key_d    = key_q;
    nbytes_d = nbytes_q;
    found_d  = found_q;
    idx_d    = idx_q;
    scan_d   = scan_q;
    used_d   = used_q;
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    do_promote = 1'b0;
    do_drop    = 1'b0;
    do_insert  = 1'b0;
    ov_d     = ov_q && !m_axis_tready;
    olast_d  = olast_q;
    ohit_d   = ohit_q;
    odv_d    = odv_q;
    oowner_d = oowner_q;
    okey_d   = okey_q;
    oused_d  = oused_q;
    ohits_d  = ohits_q;
    omiss_d  = omiss_q;
    oev_d    = oev_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d    = s_axis_tuser;
          owner_d  = s_axis_tdata[3:0];
          key_d    = s_axis_tdata[35:4];
          nbytes_d = s_axis_tdata[51:36];
          found_d  = 1'b0;
          scan_d   = '0;
          case (s_axis_tuser)
            sblc_pkg::CMD_LOOKUP, sblc_pkg::CMD_INSERT,
            sblc_pkg::CMD_REMOVE: state_d = S_SCAN;
            sblc_pkg::CMD_CLEAR:  state_d = S_CLCHK;
            sblc_pkg::CMD_RESET_STATS: begin
              hits_d   = '0;
              misses_d = '0;
              evicts_d = '0;
              state_d  = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (slot_match && !found_q) begin
          found_d = 1'b1;
          idx_d   = scan_q;
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == SW'(N - 1)) begin
          case (cmd_q)
            sblc_pkg::CMD_LOOKUP: state_d = S_LKUP;
            sblc_pkg::CMD_INSERT: state_d = S_DUP;
            default:              state_d = S_RMV;
          endcase
        end
      end
      S_DUP: begin
        if (found_q) begin
          do_drop = 1'b1;
          used_d  = used_sub;
        end
        state_d = S_EVCHK;
      end
      S_EVCHK: begin
        if (need_evict && cnt != '0 && vic_found) begin
          idx_d   = vic_idx;
          state_d = S_EVRD;
        end else begin
          state_d = S_INS;
        end
      end
      S_EVRD: begin
        if (out_free) begin
          do_drop  = 1'b1;
          used_d   = used_sub;
          evicts_d = evicts_q + 1'b1;
          ov_d     = 1'b1;
          olast_d  = 1'b0;
          ohit_d   = 1'b0;
          odv_d    = 1'b1;
          oowner_d = slot_owner_q[idx_q];
          okey_d   = slot_key_q[idx_q];
          oused_d  = used_sub;
          ohits_d  = hits_q;
          omiss_d  = misses_q;
          oev_d    = evicts_q + 1'b1;
          state_d  = S_EVCHK;
        end
      end
      S_INS: begin
        if (free_found) begin
          do_insert = 1'b1;
          used_d = ins_sum[sblc_pkg::USED_W] ? sblc_pkg::USED_MAX
                                             : ins_sum[sblc_pkg::USED_W-1:0];
        end
        state_d = S_FIN;
      end
      S_LKUP: begin
        if (found_q) begin
          do_promote = 1'b1;
          hits_d     = hits_q + 1'b1;
        end else begin
          misses_d = misses_q + 1'b1;
        end
        state_d = S_FIN;
      end
      S_RMV: begin
        if (found_q) begin
          do_drop = 1'b1;
          used_d  = used_sub;
        end
        state_d = S_FIN;
      end
      S_CLCHK: begin
        if (cnt != '0 && vic_found) begin
          idx_d   = vic_idx;
          state_d = S_CLRD;
        end else begin
          used_d  = '0;
          state_d = S_FIN;
        end
      end
      S_CLRD: begin
        if (out_free) begin
          do_drop  = 1'b1;
          used_d   = used_sub;
          ov_d     = 1'b1;
          olast_d  = 1'b0;
          ohit_d   = 1'b0;
          odv_d    = 1'b1;
          oowner_d = slot_owner_q[idx_q];
          okey_d   = slot_key_q[idx_q];
          oused_d  = used_sub;
          ohits_d  = hits_q;
          omiss_d  = misses_q;
          oev_d    = evicts_q;
          state_d  = S_CLCHK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_d     = 1'b1;
          olast_d  = 1'b1;
          ohit_d   = (cmd_q == sblc_pkg::CMD_LOOKUP) && found_q;
          odv_d    = 1'b0;
          oowner_d = '0;
          okey_d   = '0;
          oused_d  = used_q;
          ohits_d  = hits_q;
          omiss_d  = misses_q;
          oev_d    = evicts_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Parallel rank and valid update of every slot.
  always_comb begin
    valid_d = valid_q;
    for (int j = 0; j < N; j++) begin
      rank_d[j] = slot_rank_q[j];
      if (do_promote) begin
        if (valid_q[j] && slot_rank_q[j] < rrank) rank_d[j] = slot_rank_q[j] + 1'b1;
        if (SW'(j) == idx_q) rank_d[j] = '0;
      end
      if (do_drop) begin
        if (SW'(j) == idx_q) valid_d[j] = 1'b0;
        if (valid_q[j] && slot_rank_q[j] > rrank) rank_d[j] = slot_rank_q[j] - 1'b1;
      end
      if (do_insert) begin
        if (valid_q[j]) rank_d[j] = slot_rank_q[j] + 1'b1;
        if (SW'(j) == free_idx) begin
          valid_d[j] = 1'b1;
          rank_d[j]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      used_q   <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
      budget_q <= sblc_pkg::BUDGET_RESET;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      used_q   <= used_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        budget_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    owner_q  <= owner_d;
    key_q    <= key_d;
    nbytes_q <= nbytes_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    scan_q   <= scan_d;
    olast_q  <= olast_d;
    ohit_q   <= ohit_d;
    odv_q    <= odv_d;
    oowner_q <= oowner_d;
    okey_q   <= okey_d;
    oused_q  <= oused_d;
    ohits_q  <= ohits_d;
    omiss_q  <= omiss_d;
    oev_q    <= oev_d;
    for (int j = 0; j < N; j++) begin
      slot_rank_q[j] <= rank_d[j];
    end
    if (do_insert) begin
      slot_owner_q[free_idx] <= owner_q;
      slot_key_q[free_idx]   <= key_q;
      slot_bytes_q[free_idx] <= nbytes_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = {odv_q, ohit_q};
  assign m_axis_tdata  = {4'b0, oev_q, omiss_q, ohits_q, oused_q, okey_q, oowner_q};

endmodule

[hw/rtl/sblc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_checker
// Port-level checks of the size-budgeted LRU cache.
// ----------------------------------------------------------------------------
module sblc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic                             m_axis_tlast,
  input logic [1:0]                       m_axis_tuser,
  input logic [sblc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // A closing result never reports a dropped entry.
  a_last_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[1])
    else $error("closing result flags a dropped entry");

  // A hit and a dropped entry never share one result.
  a_hit_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and drop in one result");

  // The block is busy right after taking a request.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after a request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind size_budget_lru_cache_core sblc_checker u_sblc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
